/* hw/rtl/rbsi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants of the ray versus box slab intersection block.
// ----------------------------------------------------------------------------
package rbsi_pkg;

   localparam int QW          = 32;
   localparam int DIST_W      = 31;
   localparam int DIV_BITS    = 32;
   localparam int DIV_LATENCY = DIV_BITS + 2;
   localparam int SEL_LATENCY = 3;
   localparam int TOP_LATENCY = 1 + DIV_LATENCY + SEL_LATENCY;

   typedef logic signed [QW-1:0] q_type;
   typedef logic signed [QW:0]   num_type;
   typedef logic [DIST_W-1:0]    dist_type;

   localparam q_type Q_MAX = 32'sh7FFF_FFFF;
   localparam q_type Q_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      CSR_BOX_MIN_X = 3'd0,
      CSR_BOX_MIN_Y = 3'd1,
      CSR_BOX_MIN_Z = 3'd2,
      CSR_BOX_MAX_X = 3'd3,
      CSR_BOX_MAX_Y = 3'd4,
      CSR_BOX_MAX_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic     valid;
      dist_type closest_t;
   } ray_tag_type;

   typedef struct packed {
      logic neg;
      logic dzero;
      logic npos;
      logic nneg;
      logic ovf;
   } div_flag_type;

endpackage

/* hw/rtl/rbsi_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined signed Q16.16 slab divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module rbsi_div (
   input  logic             clock,
   input  rbsi_pkg::num_type num,
   input  rbsi_pkg::q_type   dir,
   output rbsi_pkg::q_type   quot
);

   localparam int NB = rbsi_pkg::DIV_BITS;

   logic [32:0]  num_mag;
   logic [31:0]  dir_mag;
   logic [48:0]  dividend;
   rbsi_pkg::div_flag_type flag_in;

   logic [31:0] rem_ff  [0:NB];
   logic [31:0] low_ff  [0:NB];
   logic [31:0] quo_ff  [0:NB];
   logic [31:0] dsr_ff  [0:NB];
   rbsi_pkg::div_flag_type flag_ff [0:NB];

   rbsi_pkg::q_type quot_in;
   rbsi_pkg::q_type quot_ff;

   always_comb begin
      num_mag  = num[32] ? 33'(-num) : 33'(num);
      dir_mag  = dir[31] ? 32'(-dir) : 32'(dir);
      dividend = {num_mag, 16'b0};
      flag_in.neg   = num[32] ^ dir[31];
      flag_in.dzero = (dir == '0);
      flag_in.npos  = !num[32] && (num != '0);
      flag_in.nneg  = num[32];
      // A quotient of 2^32 or more saturates whatever its sign.
      flag_in.ovf   = {15'b0, dividend[48:32]} >= dir_mag;
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= {15'b0, dividend[48:32]};
      low_ff[0]  <= dividend[31:0];
      quo_ff[0]  <= '0;
      dsr_ff[0]  <= dir_mag;
      flag_ff[0] <= flag_in;
   end

   for (genvar k = 0; k < NB; k++) begin : g_stage
      logic [32:0] trial;
      logic        ge;
      logic [31:0] rem_in;
      always_comb begin
         trial  = {rem_ff[k], low_ff[k][31]};
         ge     = trial >= {1'b0, dsr_ff[k]};
         rem_in = ge ? 32'(trial - {1'b0, dsr_ff[k]}) : trial[31:0];
      end
      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= rem_in;
         low_ff[k+1]  <= {low_ff[k][30:0], 1'b0};
         quo_ff[k+1]  <= {quo_ff[k][30:0], ge};
         dsr_ff[k+1]  <= dsr_ff[k];
         flag_ff[k+1] <= flag_ff[k];
      end
   end

   always_comb begin
      if (flag_ff[NB].dzero) begin
         if (flag_ff[NB].npos) begin
            quot_in = rbsi_pkg::Q_MAX;
         end else if (flag_ff[NB].nneg) begin
            quot_in = rbsi_pkg::Q_MIN;
         end else begin
            quot_in = '0;
         end
      end else if (!flag_ff[NB].neg) begin
         quot_in = (flag_ff[NB].ovf || quo_ff[NB][31]) ? rbsi_pkg::Q_MAX : quo_ff[NB];
      end else begin
         quot_in = (flag_ff[NB].ovf || quo_ff[NB] > 32'h8000_0000) ?
                   rbsi_pkg::Q_MIN : 32'(-quo_ff[NB]);
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

/* hw/rtl/rbsi_sel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_sel
// Slab ordering, entry/exit reduction and hit selection over three stages.
// ----------------------------------------------------------------------------
module rbsi_sel #(
   parameter int EPSILON = 66
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rbsi_pkg::ray_tag_type tag,
   input  rbsi_pkg::q_type       tn [3],
   input  rbsi_pkg::q_type       tf [3],
   output logic                  out_valid,
   output logic                  out_hit,
   output rbsi_pkg::q_type       out_t
);

   localparam rbsi_pkg::q_type EPS_Q = 32'(EPSILON);

   rbsi_pkg::q_type lo_in [3];
   rbsi_pkg::q_type hi_in [3];
   rbsi_pkg::q_type lo_ff [3];
   rbsi_pkg::q_type hi_ff [3];
   rbsi_pkg::ray_tag_type tag1_ff, tag2_ff;
   rbsi_pkg::q_type entry_in, exit_in, entry_ff, exit_ff;
   rbsi_pkg::q_type limit;
   logic            hit_in;
   rbsi_pkg::q_type t_in;
   logic            valid_ff, hit_ff;
   rbsi_pkg::q_type t_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         lo_in[a] = (tn[a] < tf[a]) ? tn[a] : tf[a];
         hi_in[a] = (tn[a] < tf[a]) ? tf[a] : tn[a];
      end
   end

   always_comb begin
      entry_in = lo_ff[0];
      exit_in  = hi_ff[0];
      if (lo_ff[1] > entry_in) entry_in = lo_ff[1];
      if (lo_ff[2] > entry_in) entry_in = lo_ff[2];
      if (hi_ff[1] < exit_in)  exit_in  = hi_ff[1];
      if (hi_ff[2] < exit_in)  exit_in  = hi_ff[2];
   end

   always_comb begin
      limit  = {1'b0, tag2_ff.closest_t};
      hit_in = 1'b0;
      t_in   = '0;
      if (entry_ff <= exit_ff) begin
         if (entry_ff < limit && entry_ff > EPS_Q) begin
            hit_in = 1'b1;
            t_in   = entry_ff;
         end else if (exit_ff < limit && exit_ff > EPS_Q) begin
            hit_in = 1'b1;
            t_in   = exit_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff             <= lo_in;
      hi_ff             <= hi_in;
      entry_ff          <= entry_in;
      exit_ff           <= exit_in;
      hit_ff            <= hit_in;
      t_ff              <= t_in;
      tag1_ff.closest_t <= tag.closest_t;
      tag2_ff.closest_t <= tag1_ff.closest_t;
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         tag1_ff.valid <= tag.valid;
         tag2_ff.valid <= tag1_ff.valid;
         valid_ff      <= tag2_ff.valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_hit   = hit_ff;
   assign out_t     = t_ff;

endmodule

/* hw/rtl/ray_box_slab_intersect_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_top
// Ray versus axis-aligned box test by the slab method, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
// The box corners are written through the csr_ port (index 0..2 lower corner
// x/y/z, 3..5 upper corner x/y/z, other indexes ignored); write them only
// while no transaction is in flight.
// A ray transaction is taken at every clock edge with start high; busy is
// always low, so one ray can enter in every cycle.
// Exactly one result per ray appears on rsp_hit and rsp_hit_t, marked by
// rsp_valid for one cycle. The result passes through one input register,
// the six parallel restoring dividers (one preparation stage, 32 one-bit
// stages, one saturation stage) and three selection stages. The receiver
// cannot stall, so nothing is held back.
// Reset clears the box corners to zero and drops all transactions in flight.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_top #(
   parameter int EPSILON = 66
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic signed [31:0]     req_origin_x,
   input  logic signed [31:0]     req_origin_y,
   input  logic signed [31:0]     req_origin_z,
   input  logic signed [31:0]     req_direction_x,
   input  logic signed [31:0]     req_direction_y,
   input  logic signed [31:0]     req_direction_z,
   input  logic [30:0]            req_closest_t,
   output logic                   rsp_valid,
   output logic                   rsp_hit,
   output logic signed [31:0]     rsp_hit_t,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_wdata
);

   localparam int DL = rbsi_pkg::DIV_LATENCY;

   rbsi_pkg::q_type box_min_ff [3];
   rbsi_pkg::q_type box_max_ff [3];

   logic                  valid_a_ff;
   rbsi_pkg::num_type     near_ff [3];
   rbsi_pkg::num_type     far_ff  [3];
   rbsi_pkg::q_type       dir_ff  [3];
   rbsi_pkg::dist_type    ct_ff;
   rbsi_pkg::ray_tag_type tag_ff [0:DL-1];

   rbsi_pkg::q_type org [3];
   rbsi_pkg::q_type dir [3];
   rbsi_pkg::q_type tn  [3];
   rbsi_pkg::q_type tf  [3];

   assign busy = 1'b0;

   assign org[0] = req_origin_x;
   assign org[1] = req_origin_y;
   assign org[2] = req_origin_z;
   assign dir[0] = req_direction_x;
   assign dir[1] = req_direction_y;
   assign dir[2] = req_direction_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            box_min_ff[a] <= '0;
            box_max_ff[a] <= '0;
         end
      end else if (csr_we) begin
         case (rbsi_pkg::csr_index_type'(csr_index))
            rbsi_pkg::CSR_BOX_MIN_X: box_min_ff[0] <= csr_wdata;
            rbsi_pkg::CSR_BOX_MIN_Y: box_min_ff[1] <= csr_wdata;
            rbsi_pkg::CSR_BOX_MIN_Z: box_min_ff[2] <= csr_wdata;
            rbsi_pkg::CSR_BOX_MAX_X: box_max_ff[0] <= csr_wdata;
            rbsi_pkg::CSR_BOX_MAX_Y: box_max_ff[1] <= csr_wdata;
            rbsi_pkg::CSR_BOX_MAX_Z: box_max_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input stage: the corner minus origin differences are exact at 33 bits.
   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         near_ff[a] <= 33'(box_min_ff[a]) - 33'(org[a]);
         far_ff[a]  <= 33'(box_max_ff[a]) - 33'(org[a]);
         dir_ff[a]  <= dir[a];
      end
      ct_ff <= req_closest_t;
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0].closest_t <= ct_ff;
      for (int i = 1; i < DL; i++) begin
         tag_ff[i].closest_t <= tag_ff[i-1].closest_t;
      end
      if (reset) begin
         for (int i = 0; i < DL; i++) begin
            tag_ff[i].valid <= 1'b0;
         end
      end else begin
         tag_ff[0].valid <= valid_a_ff;
         for (int i = 1; i < DL; i++) begin
            tag_ff[i].valid <= tag_ff[i-1].valid;
         end
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_axis
      rbsi_div u_div_near (
         .clock (clock),
         .num   (near_ff[a]),
         .dir   (dir_ff[a]),
         .quot  (tn[a])
      );
      rbsi_div u_div_far (
         .clock (clock),
         .num   (far_ff[a]),
         .dir   (dir_ff[a]),
         .quot  (tf[a])
      );
   end

   rbsi_sel #(
      .EPSILON (EPSILON)
   ) u_sel (
      .clock     (clock),
      .reset     (reset),
      .tag       (tag_ff[DL-1]),
      .tn        (tn),
      .tf        (tf),
      .out_valid (rsp_valid),
      .out_hit   (rsp_hit),
      .out_t     (rsp_hit_t)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(rbsi_pkg::TOP_LATENCY) rsp_valid)
      else $error("accepted transaction did not produce a result in time");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_hit_t == '0))
      else $error("miss result carries a nonzero distance");

   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_hit_t > 32'sd0 + 32'(EPSILON)))
      else $error("hit distance not above epsilon");

endmodule
